// ===== hdl/gfhc_pkg.sv =====
// Shared types and constants for the glove frame to hand command block.
// Depends on nothing; every other file depends on it.
package gfhc_pkg;

  localparam int WIN_LEN    = 20;
  localparam int FILL_W     = 5;
  localparam int CH_N       = 6;
  localparam int CH_W       = 3;
  localparam int IDX_W      = 5;
  localparam int DIV_STEPS  = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WIN_LEN - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(WIN_LEN - 1);
  localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CH_N - 1);
  localparam logic [3:0]        STEP_LAST = 4'(DIV_STEPS - 1);

  localparam logic [7:0] SYNC_BYTE = 8'h47;
  localparam logic [7:0] END_BYTE  = 8'h00;
  localparam logic [7:0] HDR0      = 8'hEB;
  localparam logic [7:0] HDR1      = 8'h90;
  localparam logic [7:0] CMD_LEN   = 8'd15;
  localparam logic [7:0] CMD_WRITE = 8'h12;
  localparam logic [7:0] ADDR_LO   = 8'hCE;
  localparam logic [7:0] ADDR_HI   = 8'h05;

  localparam logic [10:0] SCALE2   = 11'd2000;
  localparam logic [15:0] FULL_VAL = 16'd1000;
  localparam logic [15:0] NO_VAL   = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEVID  = 4'd3;

  typedef struct packed {
    logic             push;
    logic             prep;
    logic             div_step;
    logic             store;
    logic             send;
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic hand_en;
  } status_t;

endpackage

// ===== hdl/gfhc_ifs.sv =====
// Handshake channel interfaces: input bytes, command bytes and config writes.
// Depends on gfhc_pkg for widths.
interface gfhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface gfhc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_last;
  modport source (output valid, output out_byte, output frame_last, input ready);
  modport sink (input valid, input out_byte, input frame_last, output ready);
endinterface

interface gfhc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [gfhc_pkg::CFG_IDX_W-1:0]     index;
  logic [gfhc_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/gfhc_datapath.sv =====
// Datapath: byte window, config registers, channel mapping with a serial
// divider, value store and command byte selection. Depends on gfhc_pkg.
module gfhc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      in_byte,
  input  logic                            cfg_we,
  input  logic [gfhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfhc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  gfhc_pkg::cmd_t                  cmd,
  output gfhc_pkg::status_t               status,
  output logic [7:0]                      out_byte,
  output logic                            frame_last
);
  import gfhc_pkg::*;

  logic [7:0]            win [WIN_LEN];
  logic [FILL_W-1:0]     fill;
  logic [CFG_DATA_W-1:0] cal_zero;
  logic [CFG_DATA_W-1:0] cal_full;
  logic                  hand_en;
  logic [7:0]            dev_id;
  logic [7:0]            csum;
  logic [15:0]           vals [CH_N];

  logic       flag_eq, flag_zero, flag_full;
  logic [8:0] rem;
  logic [9:0] nlow;
  logic [8:0] dvs;
  logic [9:0] quo;

  logic              hit;
  logic [7:0]        raw;
  logic [5:0]        boff;
  logic signed [9:0] v, z, f, a;
  logic [7:0]        b;
  logic              gt;
  logic [18:0]       num;
  logic [9:0]        trial;
  logic [9:0]        diff;
  logic              ge;

  // A frame hits when the incoming end byte lands on a fill of nineteen with the sync byte in win[1].
  assign hit = (fill == FILL_LAST) && (win[1] == SYNC_BYTE) && (in_byte == END_BYTE);
  assign status.hit = hit;
  assign status.hand_en = hand_en;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WIN_LEN-1] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.push) begin
      if (fill != FILL_LAST) begin
        fill <= fill + FILL_W'(1);
      end else if (hit) begin
        fill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_zero <= '0;
      cal_full <= '1;
      hand_en  <= 1'b1;
      dev_id   <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO:   cal_zero <= cfg_data;
        REG_FULL:   cal_full <= cfg_data;
        REG_ENABLE: hand_en  <= cfg_data[0];
        REG_DEVID:  dev_id   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sensor taps of the frame for channels zero to five.
  always_comb begin
    unique case (cmd.ch)
      3'd0:    raw = win[13];
      3'd1:    raw = win[10];
      3'd2:    raw = win[7];
      3'd3:    raw = win[5];
      3'd4:    raw = win[3];
      3'd5:    raw = win[1];
      default: raw = 8'h00;
    endcase
  end

  assign boff = {cmd.ch, 3'b000};
  assign v  = signed'({2'b00, raw});
  assign z  = signed'({2'b00, cal_zero[boff +: 8]});
  assign f  = signed'({2'b00, cal_full[boff +: 8]});
  assign gt = f > z;
  assign a  = gt ? (v - z) : (z - v);
  assign b  = gt ? 8'(f - z) : 8'(z - f);
  // Rounded quotient is (2000*a + b) / (2*b), valid only for 0 < a < b.
  assign num = 19'(a[7:0]) * 19'(SCALE2) + 19'(b);

  assign trial = {rem, nlow[9]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      flag_eq   <= (z == f);
      flag_zero <= (a <= 10'sd0);
      flag_full <= (a > 10'sd0) && (a[7:0] >= b);
      rem       <= num[18:10];
      nlow      <= num[9:0];
      dvs       <= {b, 1'b0};
    end else if (cmd.div_step) begin
      rem  <= ge ? diff[8:0] : trial[8:0];
      quo  <= {quo[8:0], ge};
      nlow <= {nlow[8:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      priority if (flag_eq) begin
        vals[cmd.ch] <= NO_VAL;
      end else if (flag_zero) begin
        vals[cmd.ch] <= '0;
      end else if (flag_full) begin
        vals[cmd.ch] <= FULL_VAL;
      end else begin
        vals[cmd.ch] <= {6'b000000, quo};
      end
    end
  end

  always_comb begin
    unique case (cmd.idx)
      5'd0:    out_byte = HDR0;
      5'd1:    out_byte = HDR1;
      5'd2:    out_byte = dev_id;
      5'd3:    out_byte = CMD_LEN;
      5'd4:    out_byte = CMD_WRITE;
      5'd5:    out_byte = ADDR_LO;
      5'd6:    out_byte = ADDR_HI;
      5'd7:    out_byte = vals[0][7:0];
      5'd8:    out_byte = vals[0][15:8];
      5'd9:    out_byte = vals[1][7:0];
      5'd10:   out_byte = vals[1][15:8];
      5'd11:   out_byte = vals[2][7:0];
      5'd12:   out_byte = vals[2][15:8];
      5'd13:   out_byte = vals[3][7:0];
      5'd14:   out_byte = vals[3][15:8];
      5'd15:   out_byte = vals[4][7:0];
      5'd16:   out_byte = vals[4][15:8];
      5'd17:   out_byte = vals[5][7:0];
      5'd18:   out_byte = vals[5][15:8];
      5'd19:   out_byte = csum;
      default: out_byte = 8'h00;
    endcase
  end

  assign frame_last = (cmd.idx == IDX_LAST);

  // The checksum builds up as bytes two through eighteen leave.
  always_ff @(posedge clk) begin
    if (cmd.push && hit) begin
      csum <= '0;
    end else if (cmd.send && (cmd.idx >= 5'd2) && (cmd.idx != IDX_LAST)) begin
      csum <= csum + out_byte;
    end
  end

endmodule

// ===== hdl/gfhc_ctrl.sv =====
// Controller: sequences byte intake, per-channel mapping and command output.
// Depends on gfhc_pkg.
module gfhc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gfhc_pkg::status_t status,
  output gfhc_pkg::cmd_t    cmd
);
  import gfhc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_SEND  = 3'd4;

  logic [2:0]       state;
  logic [CH_W-1:0]  ch;
  logic [3:0]       step;
  logic [IDX_W-1:0] idx;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);

  assign cmd.push     = in_valid && in_ready;
  assign cmd.prep     = (state == S_PREP);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.store    = (state == S_STORE);
  assign cmd.send     = out_valid && out_ready;
  assign cmd.ch       = ch;
  assign cmd.idx      = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
      step  <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.push && status.hit && status.hand_en) begin
            state <= S_PREP;
            ch    <= '0;
          end
        end
        S_PREP: begin
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          step <= step + 4'd1;
          if (step == STEP_LAST) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (ch == CH_LAST) begin
            state <= S_SEND;
            idx   <= '0;
          end else begin
            ch    <= ch + CH_W'(1);
            state <= S_PREP;
          end
        end
        S_SEND: begin
          if (out_ready) begin
            if (idx == IDX_LAST) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/glove_frame_to_hand_command.sv =====
// Glove frame to hand command converter. An input word that completes no frame
// is taken while the controller is idle. A matching frame, when enabled, is
// mapped for six channels, each through prepare, the 10-step shared divider and
// store, then 20 command words leave at one per cycle while the sink is ready.
// Synchronous active-high reset empties the window, idles the controller and
// loads the register defaults; configuration writes are taken in any cycle.
module glove_frame_to_hand_command (
  input  logic       clk,
  input  logic       rst,
  gfhc_in_if.sink    byte_in,
  gfhc_out_if.source cmd_out,
  gfhc_cfg_if.sink   cfg
);
  import gfhc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  gfhc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .out_valid (cmd_out.valid),
    .out_ready (cmd_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gfhc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (byte_in.in_byte),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .cmd        (cmd),
    .status     (status),
    .out_byte   (cmd_out.out_byte),
    .frame_last (cmd_out.frame_last)
  );

endmodule
